>>> hdl/lzo_pkg.sv
// Package for the LZO1X stream decompressor: phase codes, action codes,
// and the command record passed from the front part to the back part.
// No dependencies.
package lzo_pkg;

	typedef enum logic [1:0] {
		ACT_FEED  = 2'd0,
		ACT_PULL  = 2'd1,
		ACT_START = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_BUSY = 2'd1,
		ST_FAR  = 2'd2,
		ST_END  = 2'd3
	} status_t;

	typedef enum logic [13:0] {
		PH_FIRST       = 14'b00000000000001,
		PH_TOP         = 14'b00000000000010,
		PH_AFTER_LIT   = 14'b00000000000100,
		PH_AFTER_TRAIL = 14'b00000000001000,
		PH_LIT_EXT     = 14'b00000000010000,
		PH_LITERALS    = 14'b00000000100000,
		PH_TRAIL_LITS  = 14'b00000001000000,
		PH_M_EXT       = 14'b00000010000000,
		PH_DIST_ONE    = 14'b00000100000000,
		PH_DIST_M1L    = 14'b00001000000000,
		PH_DIST_LO     = 14'b00010000000000,
		PH_DIST_HI     = 14'b00100000000000,
		PH_COPY        = 14'b01000000000000,
		PH_END         = 14'b10000000000000
	} phase_t;

	localparam logic [31:0] SAT_MAX   = 32'hFFFF_FFFF;
	localparam logic [16:0] M3_BASE   = 17'h00801;
	localparam logic [16:0] M4_BASE   = 17'h04000;
	localparam logic [31:0] WIN_FULL  = 32'h0000_C000;

	// One back-end operation: write a byte (literal or copy) or none.
	typedef struct packed {
		logic        wr;       // byte goes to the window and the output
		logic        rd;       // byte is read from the window
		logic        zero;     // copy of a bad match: emit zero
		logic [16:0] mdist;
		logic [7:0]  lit;
		logic        done;
		logic        pend;
		logic        need;
		logic [31:0] total;
		logic [1:0]  status;
	} op_t;

endpackage

>>> hdl/lzo_front.sv
// Front part of the LZO1X decompressor: the stream grammar state machine.
// Decodes each transaction into one back-end operation. Depends on lzo_pkg.
module lzo_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [1:0]          action,
	input  logic [7:0]          in_byte,
	output lzo_pkg::op_t        op
);

	lzo_pkg::phase_t phase_q, ph_n;
	logic [31:0] lit_q, lit_n, mlen_q, mlen_n, prod_q, prod_n;
	logic [16:0] dist_q, dist_n;
	logic [7:0]  cmd_q, cmd_n;
	logic [1:0]  trail_q, trail_n, stat_q, stat_n;
	logic        ended_q, ended_n, full_q, full_n, bad_q, bad_n;
	logic        emit, rd;
	logic [31:0] b32, tmp;
	logic [15:0] v;
	logic [16:0] d;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? lzo_pkg::SAT_MAX : s[31:0];
	endfunction

	always_comb begin
		ph_n = phase_q; lit_n = lit_q; mlen_n = mlen_q; prod_n = prod_q;
		dist_n = dist_q; cmd_n = cmd_q; trail_n = trail_q; stat_n = stat_q;
		ended_n = ended_q; full_n = full_q; bad_n = bad_q;
		emit = 1'b0; rd = 1'b0;
		b32 = {24'd0, in_byte};
		tmp = 32'd0; v = 16'd0; d = 17'd0;
		if (action == lzo_pkg::ACT_START) begin
			prod_n = '0; ph_n = lzo_pkg::PH_FIRST; lit_n = '0; mlen_n = '0; dist_n = '0;
			cmd_n = '0; trail_n = '0; ended_n = 1'b0; stat_n = '0; full_n = 1'b0; bad_n = 1'b0;
		end else if (action == lzo_pkg::ACT_FEED) begin
			if (ended_q) begin
				if (stat_q == lzo_pkg::ST_OK) stat_n = lzo_pkg::ST_END;
			end else if (phase_q == lzo_pkg::PH_COPY) begin
				if (stat_q == lzo_pkg::ST_OK) stat_n = lzo_pkg::ST_BUSY;
			end else begin
				d = 17'd0;
				tmp = 32'd0;
				if ((phase_q == lzo_pkg::PH_FIRST && in_byte <= 8'd17) ||
				    phase_q == lzo_pkg::PH_TOP || phase_q == lzo_pkg::PH_AFTER_LIT ||
				    phase_q == lzo_pkg::PH_AFTER_TRAIL) begin
					cmd_n = in_byte;
					if (in_byte >= 8'd64) ph_n = lzo_pkg::PH_DIST_ONE;
					else if (in_byte >= 8'd32 || in_byte >= 8'd16) begin
						tmp = (in_byte >= 8'd32) ? {27'd0, in_byte[4:0]} : {29'd0, in_byte[2:0]};
						mlen_n = (tmp != 0) ? tmp + 32'd2 : 32'd0;
						ph_n = (tmp != 0) ? lzo_pkg::PH_DIST_LO : lzo_pkg::PH_M_EXT;
					end else if (phase_q == lzo_pkg::PH_TOP || phase_q == lzo_pkg::PH_FIRST) begin
						lit_n = (in_byte != 0) ? b32 + 32'd3 : 32'd0;
						ph_n = (in_byte != 0) ? lzo_pkg::PH_LITERALS : lzo_pkg::PH_LIT_EXT;
					end else begin
						ph_n = (phase_q == lzo_pkg::PH_AFTER_LIT) ? lzo_pkg::PH_DIST_M1L
						                                          : lzo_pkg::PH_DIST_ONE;
					end
				end else begin
					unique case (phase_q)
						lzo_pkg::PH_FIRST: begin
							lit_n = b32 - 32'd17;
							ph_n = (lit_n < 32'd4) ? lzo_pkg::PH_TRAIL_LITS : lzo_pkg::PH_LITERALS;
						end
						lzo_pkg::PH_LIT_EXT: begin
							if (in_byte == 0) lit_n = sat_add(lit_q, 32'd255);
							else begin
								lit_n = sat_add(lit_q, 32'd18 + b32);
								ph_n = lzo_pkg::PH_LITERALS;
							end
						end
						lzo_pkg::PH_LITERALS, lzo_pkg::PH_TRAIL_LITS: begin
							emit = 1'b1;
							prod_n = prod_q + 32'd1;
							if (prod_n >= lzo_pkg::WIN_FULL) full_n = 1'b1;
							lit_n = (lit_q != 0) ? lit_q - 32'd1 : 32'd0;
							if (lit_n == 0)
								ph_n = (phase_q == lzo_pkg::PH_LITERALS) ? lzo_pkg::PH_AFTER_LIT
								                                         : lzo_pkg::PH_AFTER_TRAIL;
						end
						lzo_pkg::PH_M_EXT: begin
							if (in_byte == 0) mlen_n = sat_add(mlen_q, 32'd255);
							else begin
								mlen_n = sat_add(mlen_q, ((cmd_q >= 8'd32) ? 32'd33 : 32'd9) + b32);
								ph_n = lzo_pkg::PH_DIST_LO;
							end
						end
						lzo_pkg::PH_DIST_ONE, lzo_pkg::PH_DIST_M1L: begin
							trail_n = cmd_q[1:0];
							if (phase_q == lzo_pkg::PH_DIST_M1L) begin
								d = lzo_pkg::M3_BASE + {13'd0, cmd_q[5:2]} + {7'd0, in_byte, 2'd0};
								mlen_n = 32'd3;
							end else if (cmd_q >= 8'd64) begin
								d = 17'd1 + {14'd0, cmd_q[4:2]} + {6'd0, in_byte, 3'd0};
								mlen_n = {29'd0, cmd_q[7:5]} + 32'd1;
							end else begin
								d = 17'd1 + {13'd0, cmd_q[5:2]} + {7'd0, in_byte, 2'd0};
								mlen_n = 32'd2;
							end
							ph_n = lzo_pkg::PH_COPY;
						end
						lzo_pkg::PH_DIST_LO: begin
							dist_n = {9'd0, in_byte};
							trail_n = in_byte[1:0];
							ph_n = lzo_pkg::PH_DIST_HI;
						end
						lzo_pkg::PH_DIST_HI: begin
							v = {in_byte, dist_q[7:0]};
							if (cmd_q >= 8'd32) begin
								d = 17'd1 + {3'd0, v[15:2]};
								ph_n = lzo_pkg::PH_COPY;
							end else begin
								d = {2'd0, cmd_q[3], 14'd0} + {3'd0, v[15:2]};
								if (d == 0) begin
									ended_n = 1'b1; mlen_n = '0; ph_n = lzo_pkg::PH_END;
								end else begin
									d = d + lzo_pkg::M4_BASE;
									ph_n = lzo_pkg::PH_COPY;
								end
							end
						end
						default: ph_n = lzo_pkg::PH_TOP;
					endcase
					if (ph_n == lzo_pkg::PH_COPY) begin
						dist_n = d;
						bad_n = !full_q && ({15'd0, d} > prod_q);
						if (bad_n && stat_q == lzo_pkg::ST_OK) stat_n = lzo_pkg::ST_FAR;
					end
				end
			end
		end else if (action == lzo_pkg::ACT_PULL) begin
			if (!ended_q && phase_q == lzo_pkg::PH_COPY) begin
				emit = 1'b1; rd = 1'b1;
				prod_n = prod_q + 32'd1;
				if (prod_n >= lzo_pkg::WIN_FULL) full_n = 1'b1;
				mlen_n = (mlen_q != 0) ? mlen_q - 32'd1 : 32'd0;
				if (mlen_n == 0) begin
					bad_n = 1'b0;
					if (trail_q != 0) begin
						lit_n = {30'd0, trail_q}; ph_n = lzo_pkg::PH_TRAIL_LITS;
					end else ph_n = lzo_pkg::PH_TOP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lzo_pkg::PH_FIRST; lit_q <= '0; mlen_q <= '0; prod_q <= '0;
			dist_q <= '0; cmd_q <= '0; trail_q <= '0; stat_q <= '0;
			ended_q <= 1'b0; full_q <= 1'b0; bad_q <= 1'b0;
		end else if (fire) begin
			phase_q <= ph_n; lit_q <= lit_n; mlen_q <= mlen_n; prod_q <= prod_n;
			dist_q <= dist_n; cmd_q <= cmd_n; trail_q <= trail_n; stat_q <= stat_n;
			ended_q <= ended_n; full_q <= full_n; bad_q <= bad_n;
		end
	end

	always_comb begin
		op.wr = emit;
		op.rd = rd;
		op.zero = bad_q;
		op.mdist = dist_q;
		op.lit = in_byte;
		op.done = ended_n;
		op.pend = !ended_n && ph_n == lzo_pkg::PH_COPY;
		op.need = !ended_n && ph_n != lzo_pkg::PH_COPY;
		op.total = prod_n;
		op.status = stat_n;
	end

endmodule

>>> hdl/lzo_back.sv
// Back part of the LZO1X decompressor: history window, byte forwarding and
// the output register with a two-entry queue. Depends on lzo_pkg.
module lzo_back #(
	parameter int WINDOW_DEPTH = 65536
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_ready,
	input  lzo_pkg::op_t  op,
	output logic          m_valid,
	input  logic          m_ready,
	output logic [47:0]   m_data
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam logic [AW:0] DEPTH_W = (AW+1)'(WINDOW_DEPTH);

	logic [7:0]    mem [WINDOW_DEPTH];
	logic [AW-1:0] wpos_q;
	logic [AW:0]   dist_w;
	logic [AW:0]   idx_w;
	logic [AW-1:0] ridx;
	logic          take;
	// Stage 1: window data returned, byte resolved and written back.
	logic          v_s1;
	lzo_pkg::op_t  op_s1;
	logic [AW-1:0] wa_s1;
	logic [7:0]    rdat_s1, fwd_s1;
	logic          fwd_hit_s1;
	logic [7:0]    byte_s1;
	logic [47:0]   q_q [2];
	logic [1:0]    cnt_q;
	logic          rd_ptr_q, wr_ptr_q;
	logic          push, pop;

	always_comb begin
		dist_w = (AW+1)'(op.mdist);
		if (dist_w <= {1'b0, wpos_q})
			idx_w = {1'b0, wpos_q} - dist_w;
		else
			idx_w = {1'b0, wpos_q} + DEPTH_W - dist_w;
		ridx = idx_w[AW-1:0];
	end

	// Room is counted including the item in stage 1.
	assign op_ready = (cnt_q + {1'b0, v_s1}) < 2'd2 || pop;
	assign take = op_valid && op_ready;

	always_ff @(posedge clk) begin
		if (v_s1 && op_s1.wr) mem[wa_s1] <= byte_s1;
		rdat_s1 <= mem[ridx];
	end

	always_comb begin
		if (!op_s1.rd) byte_s1 = op_s1.lit;
		else if (op_s1.zero) byte_s1 = 8'd0;
		else if (fwd_hit_s1) byte_s1 = fwd_s1;
		else byte_s1 = rdat_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q <= '0; v_s1 <= 1'b0;
		end else begin
			v_s1 <= take;
			if (take && op.wr)
				wpos_q <= (wpos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
		end
	end

	// The byte written in stage 1 lands in the window at the same edge as the
	// next read, so it is forwarded when the addresses match.
	always_ff @(posedge clk) begin
		if (take) begin
			op_s1 <= op;
			wa_s1 <= wpos_q;
			fwd_s1 <= byte_s1;
			fwd_hit_s1 <= v_s1 && op_s1.wr && wa_s1 == ridx;
		end
	end

	assign push = v_s1;
	assign pop = m_valid && m_ready;
	assign m_valid = cnt_q != 2'd0;
	assign m_data = q_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_ptr_q <= 1'b0; wr_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_q[wr_ptr_q] <= {2'd0, op_s1.status, op_s1.total, op_s1.done, op_s1.need,
			                  op_s1.pend, (op_s1.wr ? byte_s1 : 8'd0), op_s1.wr};
	end

endmodule

>>> hdl/lzo1x_stream_decompressor.sv
// Top level of the LZO1X stream decompressor.
// Instantiates lzo_front and lzo_back; depends on lzo_pkg.
//
// Usage: one transaction on the s_axis side carries an action (feed a
// compressed byte, pull one pending match byte, start a new stream) and a
// byte. Every accepted transaction yields exactly one m_axis transaction
// carrying out_valid, out_byte, the flags, total_len and the sticky status.
// The front state machine classifies and decodes one transaction a cycle
// while s_axis_tready is high; the back part reads the history window with a
// registered read and writes the resolved byte in the following cycle,
// forwarding that byte to a read of the same address, so one transaction a
// cycle is sustained while the receiver keeps up. m_axis_tvalid rises once
// the result has passed the stage-one register and entered the output queue.
// A two-entry output queue lets the input side keep moving while the
// receiver stalls; s_axis_tready falls when the queue and the result in
// stage one together fill two entries and the receiver takes none.
// Reset clears all stream state; the window holds no reset value and no
// clearing pass is made. A start action resets stream state only.
module lzo1x_stream_decompressor #(
	parameter int WINDOW_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // action[1:0], in_byte[9:2], zeros
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata   // out_valid, out_byte, copy_pending,
	                                   // need_byte, done_res, total_len, status
);

	lzo_pkg::op_t op;
	logic         fire;

	assign fire = s_axis_tvalid && s_axis_tready;

	lzo_front u_front (
		.clk(clk), .arst_n(arst_n), .fire(fire),
		.action(s_axis_tdata[1:0]), .in_byte(s_axis_tdata[9:2]), .op(op)
	);

	lzo_back #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .op_valid(s_axis_tvalid), .op_ready(s_axis_tready),
		.op(op), .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata)
	);

	a_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
		else $error("Output byte not zero without out_valid.");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[9] && m_axis_tdata[10]))
		else $error("copy_pending and need_byte both set.");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[11] |-> !m_axis_tdata[9] && !m_axis_tdata[10])
		else $error("Flags set after end of stream.");

endmodule
